>>> rtl/r2nv_pkg.sv
// Shared constants for the RGB to NV12 converter: register codes, field widths,
// BT.601 fixed-point coefficients and the frame dimension clamp. No dependencies.
`default_nettype none

package r2nv_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 4;
    localparam int DIM_W       = 13;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = CFG_INDEX_W'(1);

    localparam int DEFAULT_MAX_WIDTH = 4096;
    localparam int MAX_HEIGHT        = 4096;
    localparam int RESET_WIDTH       = 640;
    localparam int RESET_HEIGHT      = 480;
    // largest value the 13-bit register can express
    localparam int DIM_MAX           = (1 << DIM_W) - 1;

    // Pixel and sum widths
    localparam int PIX_W   = 8;
    localparam int PAIR_W  = 9;                 // sum of two pixels
    localparam int QUAD_W  = 10;                // sum of a 2x2 block
    localparam int LINE_W  = 3 * PAIR_W;        // one line store word
    localparam int YPROD_W = 24;
    localparam int CPROD_W = 25;
    localparam int CACC_W  = 28;

    // Luma: Y = (16843 R + 33030 G + 6423 B + 1081344) >> 16
    localparam int unsigned COEF_Y_R  = 16843;
    localparam int unsigned COEF_Y_G  = 33030;
    localparam int unsigned COEF_Y_B  = 6423;
    localparam int unsigned Y_OFFSET  = 1081344;

    // Chroma over 2x2 sums, >> 18. Magnitudes; signs applied in the adder.
    localparam int unsigned COEF_U_R  = 9699;   // negative
    localparam int unsigned COEF_U_G  = 19071;  // negative
    localparam int unsigned COEF_U_B  = 28770;
    localparam int unsigned COEF_V_R  = 28770;
    localparam int unsigned COEF_V_G  = 24117;  // negative
    localparam int unsigned COEF_V_B  = 4653;   // negative
    localparam int unsigned C_OFFSET  = 33685504;

    // Clear the low bit, floor at two, saturate at the (even) limit.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] value,
                                                 input logic [DIM_W-1:0] limit);
        logic [DIM_W-1:0] e;
        logic [DIM_W-1:0] l;
        e = {value[DIM_W-1:1], 1'b0};
        l = {limit[DIM_W-1:1], 1'b0};
        if (l < DIM_W'(2)) l = DIM_W'(2);
        if (e < DIM_W'(2)) e = DIM_W'(2);
        if (e > l) e = l;
        return e;
    endfunction

endpackage

`default_nettype wire

>>> rtl/rgb_to_nv12_converter.sv
// RGB to BT.601 YCbCr 4:2:0 (NV12 order) pixel converter, top level.
// Depends on r2nv_pkg.
`default_nettype none

// One RGB pixel per clock while in_stall is low, in raster order, one result per pixel
// out. Every result carries the pixel's luma; at the odd column of an odd row it also
// carries Cb and Cr averaged over the 2x2 block, with chroma_valid set (Cb/Cr read
// zero otherwise). frame_last marks the final pixel of the frame. Throughput is one
// item per cycle while out_stall is low. Between the accepting edge and the output
// register lie the input stage (also holding the registered read of the line store),
// a product stage, and a sum/shift/clamp stage feeding the output register. Each stage
// takes a new item as soon as the one ahead moves on, so bubbles are squeezed out while
// the output is stalled. The line store keeps one 27-bit pair sum per column pair of
// an even row (MAX_WIDTH/2 entries, one write and one read port); it is not cleared
// after reset, since an odd row always follows its even row. Writing frame_width or
// frame_height restarts the frame at column 0, row 0; widths and heights are forced
// even and clamped to 2..MAX_WIDTH and 2..4096. Write configuration only while the
// block is idle.
module rgb_to_nv12_converter
    import r2nv_pkg::*;
#(
    parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   in_valid,
    output      logic                   in_stall,
    input  wire logic [PIX_W-1:0]       red,
    input  wire logic [PIX_W-1:0]       green,
    input  wire logic [PIX_W-1:0]       blue,

    output      logic                   out_valid,
    input  wire logic                   out_stall,
    output      logic [PIX_W-1:0]       luma,
    output      logic                   chroma_valid,
    output      logic [PIX_W-1:0]       cb_value,
    output      logic [PIX_W-1:0]       cr_value,
    output      logic                   frame_last,

    input  wire logic                   cfg_valid,
    output      logic                   cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]       cfg_data
);

    localparam int LINE_DEPTH  = MAX_WIDTH / 2;
    localparam int ADDR_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int COL_W       = ADDR_W + 1;
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int WIDTH_LIMIT = (MAX_WIDTH > DIM_MAX) ? DIM_MAX : MAX_WIDTH;
    localparam int CMP_W       = ((COL_W > DIM_W) ? COL_W : DIM_W) + 1;
    localparam int ROW_CMP_W   = ((ROW_W > DIM_W) ? ROW_W : DIM_W) + 1;

    localparam logic [DIM_W-1:0] WIDTH_RST  =
        eff_dim(DIM_W'(RESET_WIDTH), DIM_W'(WIDTH_LIMIT));
    localparam logic [DIM_W-1:0] HEIGHT_RST =
        eff_dim(DIM_W'(RESET_HEIGHT), DIM_W'(MAX_HEIGHT));

    // ---------------- configuration ----------------
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic             cfg_write;
    logic             cfg_hit;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        unique case (cfg_index)
            CFG_FRAME_WIDTH:  cfg_hit = 1'b1;
            CFG_FRAME_HEIGHT: cfg_hit = 1'b1;
            default:          cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_FRAME_WIDTH)
                width_reg <= eff_dim(cfg_data, DIM_W'(WIDTH_LIMIT));
            if (cfg_index == CFG_FRAME_HEIGHT)
                height_reg <= eff_dim(cfg_data, DIM_W'(MAX_HEIGHT));
        end
    end

    // ---------------- pipeline handshake ----------------
    logic s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic ready_out, ready_s2, ready_s1;
    logic accept;

    assign ready_out = !out_valid_reg || !out_stall;
    assign ready_s2  = !s2_valid_reg || ready_out;
    assign ready_s1  = !s1_valid_reg || ready_s2;
    assign in_stall  = !ready_s1;
    assign accept    = in_valid && ready_s1;

    // ---------------- raster position ----------------
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [PIX_W*3-1:0] left_reg;
    logic              row_end, frame_end;

    assign row_end   = (CMP_W'(col_reg) + CMP_W'(1)) >= CMP_W'(width_reg);
    assign frame_end = (ROW_CMP_W'(row_reg) + ROW_CMP_W'(1)) >= ROW_CMP_W'(height_reg);

    always_comb
    begin
        col_next = col_reg + COL_W'(1);
        row_next = row_reg;
        if (row_end)
        begin
            col_next = '0;
            row_next = frame_end ? '0 : row_reg + ROW_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            left_reg <= '0;
        end
        else if (cfg_write && cfg_hit)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (!col_reg[0])
                left_reg <= {red, green, blue};
        end
    end

    // ---------------- line store ----------------
    logic [PAIR_W-1:0]  pair_r, pair_g, pair_b;
    logic [ADDR_W-1:0]  line_addr;
    logic               line_we, line_re;
    logic [LINE_W-1:0]  line_mem [LINE_DEPTH];
    logic [LINE_W-1:0]  line_rd_reg;

    assign pair_r    = PAIR_W'(red)   + PAIR_W'(left_reg[3*PIX_W-1:2*PIX_W]);
    assign pair_g    = PAIR_W'(green) + PAIR_W'(left_reg[2*PIX_W-1:PIX_W]);
    assign pair_b    = PAIR_W'(blue)  + PAIR_W'(left_reg[PIX_W-1:0]);
    assign line_addr = col_reg[ADDR_W:1];
    assign line_we   = accept && col_reg[0] && !row_reg[0];
    assign line_re   = accept && col_reg[0] &&  row_reg[0];

    always_ff @(posedge clk)
    begin
        if (line_we)
            line_mem[line_addr] <= {pair_r, pair_g, pair_b};
        if (line_re)
            line_rd_reg <= line_mem[line_addr];
    end

    // ---------------- stage 1: input register ----------------
    logic [PIX_W-1:0]  s1_r_reg, s1_g_reg, s1_b_reg;
    logic [LINE_W-1:0] s1_pair_reg;
    logic              s1_chroma_reg, s1_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (ready_s1)
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_r_reg      <= red;
            s1_g_reg      <= green;
            s1_b_reg      <= blue;
            s1_pair_reg   <= {pair_r, pair_g, pair_b};
            s1_chroma_reg <= col_reg[0] && row_reg[0];
            s1_last_reg   <= row_end && frame_end;
        end
    end

    // ---------------- stage 2: products ----------------
    logic [QUAD_W-1:0]  sum_r, sum_g, sum_b;
    logic [YPROD_W-1:0] s2_yr_reg, s2_yg_reg, s2_yb_reg;
    logic [CPROD_W-1:0] s2_ur_reg, s2_ug_reg, s2_ub_reg;
    logic [CPROD_W-1:0] s2_vr_reg, s2_vg_reg, s2_vb_reg;
    logic               s2_chroma_reg, s2_last_reg;

    // 2x2 block sums: this row's pair plus the stored pair above
    assign sum_r = QUAD_W'(s1_pair_reg[3*PAIR_W-1:2*PAIR_W])
                 + QUAD_W'(line_rd_reg[3*PAIR_W-1:2*PAIR_W]);
    assign sum_g = QUAD_W'(s1_pair_reg[2*PAIR_W-1:PAIR_W])
                 + QUAD_W'(line_rd_reg[2*PAIR_W-1:PAIR_W]);
    assign sum_b = QUAD_W'(s1_pair_reg[PAIR_W-1:0])
                 + QUAD_W'(line_rd_reg[PAIR_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (ready_s2)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ready_s2 && s1_valid_reg)
        begin
            s2_yr_reg     <= YPROD_W'(s1_r_reg) * YPROD_W'(COEF_Y_R);
            s2_yg_reg     <= YPROD_W'(s1_g_reg) * YPROD_W'(COEF_Y_G);
            s2_yb_reg     <= YPROD_W'(s1_b_reg) * YPROD_W'(COEF_Y_B);
            s2_ur_reg     <= CPROD_W'(sum_r) * CPROD_W'(COEF_U_R);
            s2_ug_reg     <= CPROD_W'(sum_g) * CPROD_W'(COEF_U_G);
            s2_ub_reg     <= CPROD_W'(sum_b) * CPROD_W'(COEF_U_B);
            s2_vr_reg     <= CPROD_W'(sum_r) * CPROD_W'(COEF_V_R);
            s2_vg_reg     <= CPROD_W'(sum_g) * CPROD_W'(COEF_V_G);
            s2_vb_reg     <= CPROD_W'(sum_b) * CPROD_W'(COEF_V_B);
            s2_chroma_reg <= s1_chroma_reg;
            s2_last_reg   <= s1_last_reg;
        end
    end

    // ---------------- stage 3: sum, shift, clamp ----------------
    logic [YPROD_W:0]         y_acc;
    logic signed [CACC_W-1:0] u_acc, v_acc;
    logic [PIX_W-1:0]         u_q, v_q;

    function automatic logic [PIX_W-1:0] clamp_q(input logic signed [CACC_W-1:0] acc);
        logic [PIX_W-1:0] q;
        if (acc[CACC_W-1])
            q = '0;
        else if (|acc[CACC_W-2:18+PIX_W])
            q = '1;
        else
            q = acc[18+PIX_W-1:18];
        return q;
    endfunction

    assign y_acc = (YPROD_W+1)'(s2_yr_reg) + (YPROD_W+1)'(s2_yg_reg)
                 + (YPROD_W+1)'(s2_yb_reg) + (YPROD_W+1)'(Y_OFFSET);
    assign u_acc = $signed(CACC_W'(C_OFFSET) + CACC_W'(s2_ub_reg))
                 - $signed(CACC_W'(s2_ur_reg) + CACC_W'(s2_ug_reg));
    assign v_acc = $signed(CACC_W'(C_OFFSET) + CACC_W'(s2_vr_reg))
                 - $signed(CACC_W'(s2_vg_reg) + CACC_W'(s2_vb_reg));
    assign u_q   = clamp_q(u_acc);
    assign v_q   = clamp_q(v_acc);

    logic [PIX_W-1:0] luma_reg, cb_reg, cr_reg;
    logic             chroma_valid_reg, frame_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ready_out)
            out_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ready_out && s2_valid_reg)
        begin
            // luma peaks at 235 for 8-bit inputs, so bits above 23 stay clear
            luma_reg         <= y_acc[23:16];
            chroma_valid_reg <= s2_chroma_reg;
            cb_reg           <= s2_chroma_reg ? u_q : '0;
            cr_reg           <= s2_chroma_reg ? v_q : '0;
            frame_last_reg   <= s2_last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign luma         = luma_reg;
    assign chroma_valid = chroma_valid_reg;
    assign cb_value     = cb_reg;
    assign cr_value     = cr_reg;
    assign frame_last   = frame_last_reg;

endmodule

`default_nettype wire

>>> rtl/r2nv_checker.sv
// Port-level checks for rgb_to_nv12_converter, bound onto the top level.
// Depends on r2nv_pkg.
`default_nettype none

module r2nv_checker
    import r2nv_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             out_valid,
    input wire logic             out_stall,
    input wire logic [PIX_W-1:0] luma,
    input wire logic             chroma_valid,
    input wire logic [PIX_W-1:0] cb_value,
    input wire logic [PIX_W-1:0] cr_value,
    input wire logic             frame_last
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(luma) && $stable(cb_value) && $stable(cr_value)
                                   && $stable(chroma_valid) && $stable(frame_last))
        else $error("result changed while stalled");

    a_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !chroma_valid |-> cb_value == '0 && cr_value == '0)
        else $error("chroma nonzero without chroma_valid");

    // studio swing: chroma stays in 16..240, luma in 16..235
    a_chroma_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && chroma_valid |-> cb_value >= 8'd16 && cb_value <= 8'd240
                                      && cr_value >= 8'd16 && cr_value <= 8'd240)
        else $error("chroma out of studio range");

    a_luma_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> luma >= 8'd16 && luma <= 8'd235)
        else $error("luma out of studio range");

endmodule

bind rgb_to_nv12_converter r2nv_checker u_r2nv_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .luma         (luma),
    .chroma_valid (chroma_valid),
    .cb_value     (cb_value),
    .cr_value     (cr_value),
    .frame_last   (frame_last)
);

`default_nettype wire

>>> test/tb_rgb_to_nv12_converter.sv
// Self-checking testbench for the RGB to NV12 pixel converter.
// Drives pixel items and register writes, predicts luma and 2x2 chroma in the bench itself.
// Depends on r2nv_pkg and rgb_to_nv12_converter.

module tb_rgb_to_nv12_converter;

    import r2nv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Geometry limits and reset dimensions as the block is specified.
    localparam int MAX_COLS     = 4096;
    localparam int MAX_ROWS     = 4096;
    localparam int LINE_ENTRIES = MAX_COLS / 2;
    localparam int BOOT_WIDTH   = 640;
    localparam int BOOT_HEIGHT  = 480;
    localparam int SUM2_W       = 9;

    // BT.601 studio swing, luma in Q16 over one pixel.
    localparam int unsigned LUMA_R   = 16843;
    localparam int unsigned LUMA_G   = 33030;
    localparam int unsigned LUMA_B   = 6423;
    localparam int unsigned LUMA_OFS = 1081344;

    // Chroma in Q18 over a 2x2 sum (four pixels, so an extra >> 2 is folded in).
    localparam int CB_R   = -9699;
    localparam int CB_G   = -19071;
    localparam int CB_B   = 28770;
    localparam int CR_R   = 28770;
    localparam int CR_G   = -24117;
    localparam int CR_B   = -4653;
    localparam int CH_OFS = 33685504;

    // Register index outside the map; writes there must be ignored.
    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_TOP = '1;

    // Run ends with a failure if this many cycles pass.
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } rgb_pixel_t;

    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic             chroma_valid;
        logic [PIX_W-1:0] cb_value;
        logic [PIX_W-1:0] cr_value;
        logic             frame_last;
    } nv12_result_t;

    // Horizontal pair sums of an even row, one entry per column pair.
    typedef struct packed {
        logic [SUM2_W-1:0] r;
        logic [SUM2_W-1:0] g;
        logic [SUM2_W-1:0] b;
    } pair_sum_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    logic [PIX_W-1:0]       red       = '0;
    logic [PIX_W-1:0]       green     = '0;
    logic [PIX_W-1:0]       blue      = '0;

    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [PIX_W-1:0]       luma;
    logic                   chroma_valid;
    logic [PIX_W-1:0]       cb_value;
    logic [PIX_W-1:0]       cr_value;
    logic                   frame_last;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]       cfg_data  = '0;

    // Pixel items waiting to be driven, and results owed by the block, oldest first.
    rgb_pixel_t   pixel_backlog [$];
    nv12_result_t ycc_expected [$];

    // Bench copy of the converter state.
    logic [DIM_W-1:0] width_reg  = DIM_W'(BOOT_WIDTH);
    logic [DIM_W-1:0] height_reg = DIM_W'(BOOT_HEIGHT);
    int               col_pos    = 0;
    int               row_pos    = 0;
    rgb_pixel_t       left_px    = '0;
    pair_sum_t        pair_line [LINE_ENTRIES];

    // Idle rates, percent of cycles; changed only between phases.
    int send_gap_pct   = 16;
    int recv_stall_pct = 56;

    int         error_count = 0;
    int         cycle_count = 0;
    rgb_pixel_t drive_px;
    nv12_result_t want;

    rgb_to_nv12_converter #(
        .MAX_WIDTH    (MAX_COLS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .luma         (luma),
        .chroma_valid (chroma_valid),
        .cb_value     (cb_value),
        .cr_value     (cr_value),
        .frame_last   (frame_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Even, at least two, saturated at the limit.
    function automatic int effective_dim(input int value, input int limit);
        int e;
        e = value & ~1;
        if (e < 2)
            e = 2;
        if (e > limit)
            e = limit;
        return e;
    endfunction

    // Q18 accumulator to an 8-bit chroma byte, floored and clamped.
    function automatic logic [PIX_W-1:0] chroma_byte(input int acc);
        int q;
        if (acc < 0)
            return '0;
        q = acc >>> 18;
        if (q > 255)
            return '1;
        return q[PIX_W-1:0];
    endfunction

    // Any write in the map restarts the frame; other indexes leave everything as is.
    function automatic void apply_config(input logic [CFG_INDEX_W-1:0] idx,
                                         input logic [DIM_W-1:0] data);
        if (idx == CFG_FRAME_WIDTH)
            width_reg = data;
        else if (idx == CFG_FRAME_HEIGHT)
            height_reg = data;
        else
            return;
        col_pos = 0;
        row_pos = 0;
    endfunction

    // Result for one accepted pixel; advances the raster position.
    function automatic nv12_result_t convert_pixel(input rgb_pixel_t px);
        nv12_result_t      res;
        int unsigned       y_acc;
        logic [SUM2_W-1:0] pr;
        logic [SUM2_W-1:0] pg;
        logic [SUM2_W-1:0] pb;
        int                sr;
        int                sg;
        int                sb;
        int                line_idx;
        int                eff_w;
        int                eff_h;
        res   = '0;
        eff_w = effective_dim(int'(width_reg), MAX_COLS);
        eff_h = effective_dim(int'(height_reg), MAX_ROWS);
        y_acc = (LUMA_R * px.red + LUMA_G * px.green + LUMA_B * px.blue + LUMA_OFS) >> 16;
        res.luma = (y_acc > 255) ? '1 : y_acc[PIX_W-1:0];

        if (col_pos % 2 == 0)
        begin
            left_px = px;
        end
        else
        begin
            pr = px.red + left_px.red;
            pg = px.green + left_px.green;
            pb = px.blue + left_px.blue;
            line_idx = col_pos / 2;
            if (row_pos % 2 == 0)
            begin
                pair_line[line_idx] = {pr, pg, pb};
            end
            else
            begin
                // 2x2 block sums, 0..1020 each
                sr = int'(pr) + int'(pair_line[line_idx].r);
                sg = int'(pg) + int'(pair_line[line_idx].g);
                sb = int'(pb) + int'(pair_line[line_idx].b);
                res.chroma_valid = 1'b1;
                res.cb_value = chroma_byte(CB_R * sr + CB_G * sg + CB_B * sb + CH_OFS);
                res.cr_value = chroma_byte(CR_R * sr + CR_G * sg + CR_B * sb + CH_OFS);
            end
        end

        if (col_pos + 1 >= eff_w)
        begin
            col_pos = 0;
            if (row_pos + 1 >= eff_h)
            begin
                res.frame_last = 1'b1;
                row_pos = 0;
            end
            else
            begin
                row_pos++;
            end
        end
        else
        begin
            col_pos++;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Pixel driver: holds an item until accepted, then takes the next one
    // from the backlog unless this cycle is a gap. Each accepted item is
    // run through the predictor at the edge that accepts it.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            red      <= '0;
            green    <= '0;
            blue     <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
                ycc_expected.push_back(convert_pixel({red, green, blue}));
            if (pixel_backlog.size() > 0 && $urandom_range(0, 99) >= send_gap_pct)
            begin
                drive_px = pixel_backlog.pop_front();
                in_valid <= 1'b1;
                red      <= drive_px.red;
                green    <= drive_px.green;
                blue     <= drive_px.blue;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: checks each accepted result against the oldest
    // prediction, field by field, and draws a fresh stall every cycle.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (ycc_expected.size() == 0)
                begin
                    $error("result with none outstanding: luma %0d", luma);
                    error_count++;
                end
                else
                begin
                    want = ycc_expected.pop_front();
                    if (luma !== want.luma)
                    begin
                        $error("luma: expected %0d, actual %0d", want.luma, luma);
                        error_count++;
                    end
                    if (chroma_valid !== want.chroma_valid)
                    begin
                        $error("chroma_valid: expected %0d, actual %0d",
                               want.chroma_valid, chroma_valid);
                        error_count++;
                    end
                    if (cb_value !== want.cb_value)
                    begin
                        $error("cb_value: expected %0d, actual %0d", want.cb_value, cb_value);
                        error_count++;
                    end
                    if (cr_value !== want.cr_value)
                    begin
                        $error("cr_value: expected %0d, actual %0d", want.cr_value, cr_value);
                        error_count++;
                    end
                    if (frame_last !== want.frame_last)
                    begin
                        $error("frame_last: expected %0d, actual %0d",
                               want.frame_last, frame_last);
                        error_count++;
                    end
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing helpers
    // ------------------------------------------------------------------

    // One register write; the predictor follows at the accepting edge.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [DIM_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_config(idx, data);
        cfg_valid <= 1'b0;
    endtask

    // Block is idle once every item is in and every result is out.
    task automatic wait_drained();
        while (pixel_backlog.size() != 0 || in_valid || ycc_expected.size() != 0)
            @(posedge clk);
    endtask

    // Channel value, leaning toward the rails one time in eight.
    function automatic logic [PIX_W-1:0] rand_channel();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? '1 : '0;
        return PIX_W'($urandom_range(0, 255));
    endfunction

    task automatic queue_random_pixels(input int count);
        for (int i = 0; i < count; i++)
            pixel_backlog.push_back({rand_channel(), rand_channel(), rand_channel()});
    endtask

    function automatic logic [DIM_W-1:0] rand_dim(input int hi);
        if ($urandom_range(0, 3) == 0)
            return DIM_W'($urandom_range(0, 3));     // 0..3, all forced to the floor of two
        return DIM_W'($urandom_range(2, hi));
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        rgb_pixel_t block_color [4];
        int         frame_px;
        int         count;
        int         small_items;
        int         pick;

        block_color[0] = {8'h00, 8'h00, 8'h00};   // black: neutral chroma
        block_color[1] = {8'hFF, 8'hFF, 8'hFF};   // white: neutral chroma
        block_color[2] = {8'h00, 8'h00, 8'hFF};   // blue: Cb at its top
        block_color[3] = {8'hFF, 8'h00, 8'h00};   // red: Cr at its top

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, at the reset geometry: luma extremes and bit patterns.
        pixel_backlog.push_back({8'h00, 8'h00, 8'h00});
        pixel_backlog.push_back({8'hFF, 8'hFF, 8'hFF});
        pixel_backlog.push_back({8'hFF, 8'h00, 8'h00});
        pixel_backlog.push_back({8'h00, 8'hFF, 8'h00});
        pixel_backlog.push_back({8'h00, 8'h00, 8'hFF});
        pixel_backlog.push_back({8'hAA, 8'h55, 8'hAA});
        pixel_backlog.push_back({8'h55, 8'hAA, 8'h55});
        pixel_backlog.push_back({8'h7F, 8'h80, 8'h01});
        wait_drained();

        // Carry the reset frame on into its second 640-pixel row, so the reset
        // width shows up in where chroma starts.
        queue_random_pixels(660);
        wait_drained();

        // Directed 4x4 frame, four solid 2x2 blocks with the chroma extremes.
        // An out-of-map write first: it must not restart the frame or change it.
        write_reg(CFG_INDEX_TOP, '1);
        write_reg(CFG_FRAME_WIDTH, DIM_W'(4));
        write_reg(CFG_FRAME_HEIGHT, DIM_W'(4));
        for (int row = 0; row < 4; row++)
            for (int col = 0; col < 4; col++)
                pixel_backlog.push_back(block_color[(row / 2) * 2 + col / 2]);
        wait_drained();

        // Random small frames; idle profile moves through the three settings.
        small_items = 0;
        while (small_items < 760)
        begin
            if (small_items < 250)
            begin
                send_gap_pct   = 16;
                recv_stall_pct = 56;
            end
            else if (small_items < 500)
            begin
                send_gap_pct   = 56;
                recv_stall_pct = 16;
            end
            else
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end

            pick = $urandom_range(0, 3);
            if (pick != 1)
                write_reg(CFG_FRAME_WIDTH, rand_dim(40));
            if (pick != 0)
                write_reg(CFG_FRAME_HEIGHT, rand_dim(8));

            frame_px = effective_dim(int'(width_reg), MAX_COLS)
                     * effective_dim(int'(height_reg), MAX_ROWS);
            case ($urandom_range(0, 3))
                0:       count = $urandom_range(1, frame_px);   // stop mid-frame
                1:       count = 2 * frame_px;                  // roll into a second frame
                default: count = frame_px;
            endcase
            queue_random_pixels(count);
            small_items += count;

            // Now and then an out-of-map write mid-frame, then carry on.
            if ($urandom_range(0, 5) == 0)
            begin
                wait_drained();
                write_reg(CFG_INDEX_W'($urandom_range(int'(CFG_FRAME_HEIGHT) + 1,
                                                      int'(CFG_INDEX_TOP))),
                          DIM_W'($urandom));
                count = $urandom_range(1, frame_px);
                queue_random_pixels(count);
                small_items += count;
            end
            wait_drained();
        end

        // Widest setting: width above the limit saturates at 4096, height below
        // the floor goes to two. A short run into the first row.
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        write_reg(CFG_FRAME_WIDTH, '1);
        write_reg(CFG_FRAME_HEIGHT, DIM_W'(1));
        queue_random_pixels(96);
        wait_drained();

        // Tallest setting: zero width means two columns, height saturates at 4096.
        // The first rows only.
        write_reg(CFG_FRAME_WIDTH, '0);
        write_reg(CFG_FRAME_HEIGHT, '1);
        queue_random_pixels(96);
        wait_drained();

        // Let anything stray come out before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
rtl/r2nv_pkg.sv
rtl/rgb_to_nv12_converter.sv
rtl/r2nv_checker.sv
test/tb_rgb_to_nv12_converter.sv
